FILE: rtl/core/avd_pkg.sv
// Shared constants, register codes and the controller state type for the
// autocorrelation voicing detector. No dependencies.
package avd_pkg;

    // Storage geometry
    localparam int RING_DEPTH  = 1024;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int RING_HALF   = RING_DEPTH / 2;
    localparam int LAG_SLOTS   = 512;
    localparam int LAG_AW      = $clog2(LAG_SLOTS);
    localparam int LAG_W       = $clog2(RING_HALF) + 1;

    // Arithmetic widths
    localparam int SAMPLE_BITS = 16;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int SUM_BITS    = 48;
    localparam int MUL_HALF    = SUM_BITS / 2;
    localparam int MAG_SQ_BITS = 2 * SUM_BITS;
    localparam int Q_BITS      = 16;
    localparam int Q_IDX_W     = $clog2(Q_BITS);
    localparam int CMP_BITS    = MAG_SQ_BITS + 2 * Q_BITS;
    localparam int COEF_W      = 16;

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SHORT_W     = 9;
    localparam int LONG_W      = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORTEST_LAG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONGEST_LAG   = 3'd4;

    localparam logic [SHORT_W-1:0] SHORT_RESET = 9'd8;
    localparam logic [LONG_W-1:0]  LONG_RESET  = 10'd128;

    // Controller states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_OLD_RD,
        S_OLD_CAP,
        S_OLD_SQ,
        S_ENERGY,
        S_LAG_RD,
        S_LAG_CAP,
        S_LAG_XP,
        S_LAG_CROSS,
        S_LAG_EN,
        S_LAG_CHK,
        S_MUL,
        S_SEARCH,
        S_NEXT,
        S_FIN1,
        S_FIN2,
        S_EMIT
    } t_avd_state;

endpackage

FILE: rtl/core/avd_if.sv
// Stream interfaces for the voicing detector: sample input and result output.
// Depends on avd_pkg for the field widths.
interface avd_sample_if import avd_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_BITS-1:0]  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface avd_result_if import avd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [Q_BITS-1:0]   voicing_level;
    logic [Q_BITS-1:0]   peak_correlation;

    modport source (output valid, output voicing_level, output peak_correlation, input ready);
    modport sink   (input valid, input voicing_level, input peak_correlation, output ready);
endinterface

FILE: rtl/core/avd_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
module avd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read ports (read returns the old data).
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: rtl/core/autocorrelation_voicing_detector.sv
// Channel      Dir  Payload                                   Handshake
// i_sample     in   sample_in (s16, Q1.15)                    valid/ready
// o_result     out  voicing_level, peak_correlation (u16)     valid/ready
// cfg write    in   i_cfg_index, i_cfg_data                   i_cfg_we
//
// An enabled sample runs from one accept to the next through every lag searched;
// when both energies are positive the per-lag cost is set by the shared 24x24
// multiplier (two 48x48 products) and the 16-step bit search. A disabled sample
// goes from accept straight to the emit state.
// After reset a clearing pass over RING_DEPTH addresses zeroes the ring and lag
// memories; no sample is taken then.
// The result register lets the next sample enter while a result is stalled.
// Depends on avd_pkg, avd_if and avd_ram.
module autocorrelation_voicing_detector import avd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    avd_sample_if.sink             i_sample,
    avd_result_if.source           o_result
);

    t_avd_state r_state, n_state;

    // Configuration registers
    logic                 r_cfg_enable;
    logic [COEF_W-1:0]    r_cfg_attack, r_cfg_release;
    logic [SHORT_W-1:0]   r_cfg_short;
    logic [LONG_W-1:0]    r_cfg_long;

    // Control state
    logic [RING_AW-1:0]   r_clr, r_wp;
    logic [SUM_BITS-1:0]  r_energy;
    logic [Q_BITS-1:0]    r_smooth;
    logic                 r_ov;
    logic [Q_BITS-1:0]    r_o_voice, r_o_peak;

    // Datapath registers
    logic signed [SAMPLE_BITS-1:0] r_x, r_old, r_a, r_b;
    logic signed [PROD_BITS-1:0]   r_p1, r_p2;
    logic [SUM_BITS-1:0]  r_cross, r_el, r_ma, r_mb;
    logic [LAG_W-1:0]     r_s, r_l, r_w, r_lag;
    logic                 r_none;
    logic [Q_BITS-1:0]    r_peak, r_q, r_tgt, r_res_v, r_res_p;
    logic [Q_IDX_W-1:0]   r_bit;
    logic [2:0]           r_step;
    logic [1:0]           r_pidx;
    logic [2*MUL_HALF-1:0] r_pp;
    logic [MAG_SQ_BITS-1:0] r_acc;
    logic                 r_which;
    logic [CMP_BITS-1:0]  r_rhs, r_qa, r_bs, r_ps;

    // Memory ports
    logic                 ring_we;
    logic [RING_AW-1:0]   ring_waddr, ring_raddr_a, ring_raddr_b;
    logic [SAMPLE_BITS-1:0] ring_wdata, ring_rd_a, ring_rd_b;
    logic                 lag_we;
    logic [LAG_AW-1:0]    lag_waddr, lag_raddr, lag_slot;
    logic [2*SUM_BITS-1:0] lag_wdata, lag_rd;

    logic                 in_accept;

    avd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk     (i_clk),
        .i_we      (ring_we),
        .i_waddr   (ring_waddr),
        .i_wdata   (ring_wdata),
        .i_raddr_a (ring_raddr_a),
        .i_raddr_b (ring_raddr_b),
        .o_rdata_a (ring_rd_a),
        .o_rdata_b (ring_rd_b)
    );

    avd_ram #(.WIDTH(2*SUM_BITS), .DEPTH(LAG_SLOTS)) u_lags (
        .i_clk     (i_clk),
        .i_we      (lag_we),
        .i_waddr   (lag_waddr),
        .i_wdata   (lag_wdata),
        .i_raddr_a (lag_raddr),
        .i_raddr_b (lag_raddr),
        .o_rdata_a (lag_rd),
        .o_rdata_b ()
    );

    // Effective lag range from the configuration.
    logic [SHORT_W-1:0] s_eff;
    logic [LAG_W-1:0]   l_half, l_eff, s_ext, w_eff;
    logic [LAG_W:0]     l_cap;

    always_comb begin
        s_eff  = (r_cfg_short == '0) ? SHORT_W'(1) : r_cfg_short;
        s_ext  = LAG_W'(s_eff);
        l_half = (LAG_W'(r_cfg_long) > LAG_W'(RING_HALF)) ? LAG_W'(RING_HALF)
                                                          : LAG_W'(r_cfg_long);
        l_cap  = (LAG_W+1)'(s_eff) + (LAG_W+1)'(LAG_SLOTS - 1);
        l_eff  = ({1'b0, l_half} > l_cap) ? l_cap[LAG_W-1:0] : l_half;
        w_eff  = (l_eff >= s_ext) ? (l_eff - s_ext) : '0;
    end

    assign lag_slot = LAG_AW'(r_lag - r_s);

    // Energy sign checks and correlation magnitude.
    logic e0_pos, el_pos;
    logic [SUM_BITS-1:0] cross_mag;

    assign e0_pos    = !r_energy[SUM_BITS-1] && (r_energy != '0);
    assign el_pos    = !r_el[SUM_BITS-1] && (r_el != '0);
    assign cross_mag = r_cross[SUM_BITS-1] ? (SUM_BITS'(0) - r_cross) : r_cross;

    // Sign-extended products for the running sums.
    logic [SUM_BITS-1:0] p1_ext, p2_ext;

    assign p1_ext = {{(SUM_BITS-PROD_BITS){r_p1[PROD_BITS-1]}}, r_p1};
    assign p2_ext = {{(SUM_BITS-PROD_BITS){r_p2[PROD_BITS-1]}}, r_p2};

    // Shared multiplier: one 24x24 partial product per cycle.
    logic [MUL_HALF-1:0]    mul_a_half, mul_b_half;
    logic [MAG_SQ_BITS-1:0] mul_shifted, mul_sum;

    always_comb begin
        mul_a_half = r_step[1] ? r_ma[SUM_BITS-1:MUL_HALF] : r_ma[MUL_HALF-1:0];
        mul_b_half = r_step[0] ? r_mb[SUM_BITS-1:MUL_HALF] : r_mb[MUL_HALF-1:0];
        case (r_pidx)
            2'd0:    mul_shifted = MAG_SQ_BITS'(r_pp);
            2'd3:    mul_shifted = MAG_SQ_BITS'(r_pp) << (2 * MUL_HALF);
            default: mul_shifted = MAG_SQ_BITS'(r_pp) << MUL_HALF;
        endcase
        mul_sum = r_acc + ((r_step != '0) ? mul_shifted : '0);
    end

    // Quotient bit search: compares E0*EL*t^2 against C^2 * 2^32.
    logic [CMP_BITS-1:0] srch_t;
    logic                srch_ok;

    assign srch_t  = r_qa + r_bs + r_ps;
    assign srch_ok = (srch_t <= r_rhs);

    // Voicing target and smoothing.
    logic [Q_BITS-1:0]     tgt_d;
    logic [2*Q_BITS-1:0]   tgt_sq;
    logic                  sm_up;
    logic [Q_BITS-1:0]     sm_diff, sm_delta, sm_next;
    logic [COEF_W:0]       sm_coef;
    logic [2*COEF_W:0]     sm_prod;

    always_comb begin
        tgt_d    = r_peak[Q_BITS-1] ? {r_peak[Q_BITS-2:0], 1'b0} : '0;
        tgt_sq   = tgt_d * tgt_d;
        sm_up    = (r_tgt > r_smooth);
        sm_diff  = sm_up ? (r_tgt - r_smooth) : (r_smooth - r_tgt);
        sm_coef  = (COEF_W+1)'(1 << COEF_W) -
                   {1'b0, (sm_up ? r_cfg_attack : r_cfg_release)};
        sm_prod  = (2*COEF_W+1)'(sm_diff) * (2*COEF_W+1)'(sm_coef);
        sm_delta = sm_prod[2*COEF_W-1:COEF_W];
        sm_next  = sm_up ? (r_smooth + sm_delta) : (r_smooth - sm_delta);
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, handshake and memory controls.
    always_comb begin
        n_state        = r_state;
        i_sample.ready = 1'b0;
        ring_we        = 1'b0;
        ring_waddr     = r_wp;
        ring_wdata     = r_x;
        ring_raddr_a   = r_wp - RING_AW'(r_lag);
        ring_raddr_b   = r_wp - RING_AW'(r_w) - RING_AW'(r_lag);
        lag_we         = 1'b0;
        lag_waddr      = lag_slot;
        lag_wdata      = {r_cross, r_el};
        lag_raddr      = lag_slot;
        unique case (r_state)
            S_CLEAR: begin
                ring_we    = 1'b1;
                ring_waddr = r_clr;
                ring_wdata = '0;
                lag_we     = 1'b1;
                lag_waddr  = r_clr[LAG_AW-1:0];
                lag_wdata  = '0;
                if (r_clr == RING_AW'(RING_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_sample.ready = 1'b1;
                if (i_sample.valid) begin
                    n_state = r_cfg_enable ? S_OLD_RD : S_EMIT;
                end
            end
            S_OLD_RD: begin
                ring_raddr_a = r_wp - RING_AW'(r_w);
                n_state      = S_OLD_CAP;
            end
            S_OLD_CAP:   n_state = S_OLD_SQ;
            S_OLD_SQ:    n_state = S_ENERGY;
            S_ENERGY:    n_state = r_none ? S_FIN1 : S_LAG_RD;
            S_LAG_RD:    n_state = S_LAG_CAP;
            S_LAG_CAP:   n_state = S_LAG_XP;
            S_LAG_XP:    n_state = S_LAG_CROSS;
            S_LAG_CROSS: n_state = S_LAG_EN;
            S_LAG_EN:    n_state = S_LAG_CHK;
            S_LAG_CHK: begin
                lag_we  = 1'b1;
                n_state = (e0_pos && el_pos) ? S_MUL : S_NEXT;
            end
            S_MUL: begin
                if (r_step == 3'd4 && r_which) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_bit == '0) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: n_state = (r_lag == r_l) ? S_FIN1 : S_LAG_RD;
            S_FIN1: begin
                ring_we = 1'b1;
                n_state = S_FIN2;
            end
            S_FIN2: n_state = S_EMIT;
            S_EMIT: begin
                if (!r_ov || o_result.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign in_accept = i_sample.valid && i_sample.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_enable  <= 1'b0;
            r_cfg_attack  <= '0;
            r_cfg_release <= '0;
            r_cfg_short   <= SHORT_RESET;
            r_cfg_long    <= LONG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DETECT_ENABLE: r_cfg_enable  <= i_cfg_data[0];
                CFG_ATTACK_COEFF:  r_cfg_attack  <= i_cfg_data[COEF_W-1:0];
                CFG_RELEASE_COEFF: r_cfg_release <= i_cfg_data[COEF_W-1:0];
                CFG_SHORTEST_LAG:  r_cfg_short   <= i_cfg_data[SHORT_W-1:0];
                CFG_LONGEST_LAG:   r_cfg_long    <= i_cfg_data[LONG_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state: clear sweep, write position, window energy, smoothing,
    // and the result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_wp     <= '0;
            r_energy <= '0;
            r_smooth <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_ENERGY) begin
                r_energy <= r_energy + p1_ext - p2_ext;
            end
            if (r_state == S_FIN1) begin
                r_wp <= r_wp + 1'b1;
            end
            if (r_state == S_FIN2) begin
                r_smooth <= sm_next;
            end
            if (r_state == S_EMIT && (!r_ov || o_result.ready)) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && (!r_ov || o_result.ready)) begin
            r_o_voice <= r_res_v;
            r_o_peak  <= r_res_p;
        end
    end

    assign o_result.valid            = r_ov;
    assign o_result.voicing_level    = r_o_voice;
    assign o_result.peak_correlation = r_o_peak;

    // Datapath registers, advanced by the controller state.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_x     <= i_sample.sample_in;
                    r_s     <= s_ext;
                    r_l     <= l_eff;
                    r_w     <= w_eff;
                    r_none  <= (l_eff < s_ext);
                    r_peak  <= '0;
                    r_res_v <= r_smooth;
                    r_res_p <= '0;
                end
            end
            S_OLD_CAP: r_old <= ring_rd_a;
            S_OLD_SQ: begin
                r_p1 <= r_x * r_x;
                r_p2 <= r_old * r_old;
            end
            S_ENERGY: r_lag <= r_s;
            S_LAG_CAP: begin
                r_a     <= ring_rd_a;
                r_b     <= ring_rd_b;
                r_cross <= lag_rd[2*SUM_BITS-1:SUM_BITS];
                r_el    <= lag_rd[SUM_BITS-1:0];
            end
            S_LAG_XP: begin
                r_p1 <= r_x * r_a;
                r_p2 <= r_old * r_b;
            end
            S_LAG_CROSS: begin
                r_cross <= r_cross + p1_ext - p2_ext;
                r_p1    <= r_a * r_a;
                r_p2    <= r_b * r_b;
            end
            S_LAG_EN: r_el <= r_el + p1_ext - p2_ext;
            S_LAG_CHK: begin
                r_ma    <= cross_mag;
                r_mb    <= cross_mag;
                r_which <= 1'b0;
                r_step  <= '0;
                r_acc   <= '0;
                r_q     <= '0;
            end
            S_MUL: begin
                if (r_step != 3'd4) begin
                    r_pp   <= mul_a_half * mul_b_half;
                    r_pidx <= r_step[1:0];
                    r_acc  <= mul_sum;
                    r_step <= r_step + 1'b1;
                end else if (!r_which) begin
                    // C^2 done; start E0*EL.
                    r_rhs   <= {mul_sum, {(2*Q_BITS){1'b0}}};
                    r_ma    <= r_energy;
                    r_mb    <= r_el;
                    r_which <= 1'b1;
                    r_step  <= '0;
                    r_acc   <= '0;
                end else begin
                    r_qa  <= '0;
                    r_bs  <= '0;
                    r_ps  <= CMP_BITS'(mul_sum) << (2 * (Q_BITS - 1));
                    r_bit <= Q_IDX_W'(Q_BITS - 1);
                end
            end
            S_SEARCH: begin
                // Keep E*q^2 and E*q shifted in step so only adds remain.
                if (srch_ok) begin
                    r_qa       <= srch_t;
                    r_q[r_bit] <= 1'b1;
                    r_bs       <= (r_bs >> 1) + r_ps;
                end else begin
                    r_bs <= r_bs >> 1;
                end
                r_ps  <= r_ps >> 2;
                r_bit <= r_bit - 1'b1;
            end
            S_NEXT: begin
                if (r_q > r_peak) begin
                    r_peak <= r_q;
                end
                r_lag <= r_lag + 1'b1;
            end
            S_FIN1: r_tgt <= tgt_sq[2*Q_BITS-1:Q_BITS];
            S_FIN2: begin
                r_res_v <= sm_next;
                r_res_p <= r_peak;
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    // The accepted partial square never exceeds the bound it is tested against.
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_qa <= r_rhs))
        else $error("search accumulator exceeds bound");

    // Lag walk stays inside the latched range.
    a_lag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAG_RD) |-> (r_lag >= r_s && r_lag <= r_l))
        else $error("lag outside range");

    // A result loaded from the emit state is presented next cycle.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (!r_ov || o_result.ready)) |=> o_result.valid)
        else $error("result not presented");
`endif

endmodule
